// File: design/graph_connectivity_heavy_edge_prune_unit_assert.svh
// Assertion macros shared by the connectivity/prune unit files.
`ifndef GRAPH_CONNECTIVITY_HEAVY_EDGE_PRUNE_UNIT_ASSERT_SVH
`define GRAPH_CONNECTIVITY_HEAVY_EDGE_PRUNE_UNIT_ASSERT_SVH

// Same-cycle implication.
`define GCP_ASSERT_NOW(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("gcp assertion failed");

// Next-cycle implication.
`define GCP_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("gcp assertion failed");

`endif

// File: design/gcp_pkg.sv
// Shared constants and types for the connectivity/prune unit.
`timescale 1ns / 1ps
package gcp_pkg;

   localparam int MAX_VERTICES = 16;
   localparam int VTX_W        = $clog2(MAX_VERTICES);
   localparam int CNT_W        = $clog2(MAX_VERTICES + 1);
   localparam int ADDR_W       = 2 * VTX_W;
   localparam int MEM_DEPTH    = MAX_VERTICES * MAX_VERTICES;
   localparam int WEIGHT_W     = 16;
   localparam int CSR_W        = 5;
   localparam int REQ_DATA_W   = 24;
   localparam int RSP_DATA_W   = 24;

   localparam logic [CSR_W-1:0] VCOUNT_RESET = CSR_W'(16);

   localparam logic [1:0] CMD_WRITE = 2'd0;
   localparam logic [1:0] CMD_CHECK = 2'd1;
   localparam logic [1:0] CMD_PRUNE = 2'd2;
   localparam logic [1:0] CMD_READ  = 2'd3;

   localparam logic [1:0] MARK_UNVISITED = 2'd1;
   localparam logic [1:0] MARK_FRONTIER  = 2'd2;
   localparam logic [1:0] MARK_DONE      = 2'd3;

   typedef struct packed {
      logic             init;
      logic [CNT_W-1:0] n_eff;
      logic             take;
      logic [VTX_W-1:0] take_idx;
      logic             visit;
      logic [VTX_W-1:0] visit_idx;
   } mark_ctrl_type;

   typedef struct packed {
      logic             any_frontier;
      logic [VTX_W-1:0] first_idx;
      logic             all_reached;
   } mark_stat_type;

endpackage

// File: design/gcp_mark_unit.sv
// Vertex mark table with frontier search for the reachability walk.
`timescale 1ns / 1ps
`include "graph_connectivity_heavy_edge_prune_unit_assert.svh"
module gcp_mark_unit import gcp_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  mark_ctrl_type ctrl,
   output mark_stat_type stat
);

   logic [1:0] marks_ff [MAX_VERTICES];
   logic [1:0] marks_in [MAX_VERTICES];

   always_comb begin
      for (int v = 0; v < MAX_VERTICES; v++) begin
         marks_in[v] = marks_ff[v];
         if (ctrl.init) begin
            if (CNT_W'(v) >= ctrl.n_eff) begin
               marks_in[v] = MARK_DONE;
            end else if (v == 1) begin
               marks_in[v] = MARK_FRONTIER;
            end else begin
               marks_in[v] = MARK_UNVISITED;
            end
         end else if (ctrl.take && ctrl.take_idx == VTX_W'(v)) begin
            marks_in[v] = MARK_DONE;
         end else if (ctrl.visit && ctrl.visit_idx == VTX_W'(v)
                      && marks_ff[v] == MARK_UNVISITED) begin
            marks_in[v] = MARK_FRONTIER;
         end
      end
   end

   always_ff @(posedge clock) begin
      for (int v = 0; v < MAX_VERTICES; v++) begin
         if (reset) begin
            marks_ff[v] <= MARK_UNVISITED;
         end else begin
            marks_ff[v] <= marks_in[v];
         end
      end
   end

   // lowest-numbered frontier vertex, and whether no vertex is still unvisited
   always_comb begin
      stat.any_frontier = 1'b0;
      stat.first_idx    = '0;
      stat.all_reached  = 1'b1;
      for (int v = MAX_VERTICES - 1; v >= 0; v--) begin
         if (marks_ff[v] == MARK_FRONTIER) begin
            stat.any_frontier = 1'b1;
            stat.first_idx    = VTX_W'(v);
         end
         if (marks_ff[v] == MARK_UNVISITED) begin
            stat.all_reached = 1'b0;
         end
      end
   end

   `GCP_ASSERT_NOW(a_take_frontier, clock, reset, ctrl.take, marks_ff[ctrl.take_idx] == MARK_FRONTIER)
   `GCP_ASSERT_NEXT(a_init_seed, clock, reset, ctrl.init, marks_ff[1] == MARK_FRONTIER)
   `GCP_ASSERT_NOW(a_visit_range, clock, reset, ctrl.visit, {1'b0, ctrl.visit_idx} < ctrl.n_eff)

endmodule

// File: design/graph_connectivity_heavy_edge_prune_unit.sv
// Top level: weight matrix memory, command sequencer and result register.
// Write, check and read take one reachability walk: per reached vertex a
// frontier search, then a read of its row. Prune, if that walk reaches all
// vertices, adds a full-matrix max sweep, a second walk and, if still connected,
// a zeroing sweep. One matrix entry is read per cycle while a row or the matrix is
// swept; the next word is taken only once the previous result sits in the output reg.
// Reset clears control, marks and the result valid flag; vertex_count goes to 16.
`timescale 1ns / 1ps
`include "graph_connectivity_heavy_edge_prune_unit_assert.svh"
module graph_connectivity_heavy_edge_prune_unit import gcp_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [REQ_DATA_W-1:0] req_tdata,   // row[3:0], col[7:4], weight[23:8]
   input  logic [1:0]            req_tuser,   // cmd[1:0]
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [RSP_DATA_W-1:0] rsp_tdata,   // connected[0], pruned[1], read_weight[17:2]
   input  logic                  csr_wr_en,
   input  logic [CSR_W-1:0]      csr_wr_data
);

   localparam logic [3:0] S_IDLE       = 4'd0;
   localparam logic [3:0] S_READ_CAP   = 4'd1;
   localparam logic [3:0] S_INIT       = 4'd2;
   localparam logic [3:0] S_FIND       = 4'd3;
   localparam logic [3:0] S_WALK       = 4'd4;
   localparam logic [3:0] S_WALK_DRAIN = 4'd5;
   localparam logic [3:0] S_MAX        = 4'd6;
   localparam logic [3:0] S_MAX_DRAIN  = 4'd7;
   localparam logic [3:0] S_ZERO       = 4'd8;
   localparam logic [3:0] S_ZERO_DRAIN = 4'd9;
   localparam logic [3:0] S_RESULT     = 4'd10;

   localparam logic [1:0] PH_PLAIN = 2'd0;
   localparam logic [1:0] PH_CHECK = 2'd1;
   localparam logic [1:0] PH_SKIP  = 2'd2;

   logic [CSR_W-1:0] vcount_ff;
   logic [CNT_W-1:0] n_eff;
   logic [VTX_W-1:0] nm1;

   logic [3:0]       state_ff, state_in;
   logic [1:0]       phase_ff, phase_in;
   logic             inside_ff, inside_in;
   logic [VTX_W-1:0] scan_r_ff, scan_r_in;
   logic [VTX_W-1:0] scan_c_ff, scan_c_in;
   logic             rd_vld_ff, rd_vld_in;
   logic [ADDR_W-1:0] rd_addr_ff, rd_addr_in;
   logic signed [WEIGHT_W-1:0] top_ff, top_in;
   logic             top_first_ff, top_first_in;
   logic             conn_ff, conn_in;
   logic             pruned_ff, pruned_in;
   logic [WEIGHT_W-1:0] rd_ff, rd_in;
   logic             rsp_valid_ff, rsp_valid_in;
   logic [RSP_DATA_W-1:0] rsp_data_ff, rsp_data_in;

   logic [WEIGHT_W-1:0] mem [MEM_DEPTH];
   logic signed [WEIGHT_W-1:0] mem_rdata_ff;
   logic                mem_we;
   logic [ADDR_W-1:0]   mem_waddr;
   logic [WEIGHT_W-1:0] mem_wdata;
   logic [ADDR_W-1:0]   mem_raddr;

   logic [1:0]          req_cmd;
   logic [VTX_W-1:0]    req_row;
   logic [VTX_W-1:0]    req_col;
   logic [WEIGHT_W-1:0] req_weight;
   logic                req_inside;
   logic                accept;
   logic                is_edge;
   logic                in_zero;
   logic                in_sweep;

   mark_ctrl_type mctrl;
   mark_stat_type mstat;

   assign req_cmd    = req_tuser;
   assign req_row    = req_tdata[3:0];
   assign req_col    = req_tdata[7:4];
   assign req_weight = req_tdata[23:8];

   assign n_eff = (vcount_ff < CSR_W'(2)) ? CNT_W'(2) :
                  (vcount_ff > CSR_W'(MAX_VERTICES)) ? CNT_W'(MAX_VERTICES) :
                  CNT_W'(vcount_ff);
   assign nm1   = VTX_W'(n_eff - CNT_W'(1));
   assign req_inside = ({1'b0, req_row} < n_eff) && ({1'b0, req_col} < n_eff);

   assign req_tready = (state_ff == S_IDLE);
   assign accept     = req_tvalid && req_tready;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   assign in_zero  = (state_ff == S_ZERO) || (state_ff == S_ZERO_DRAIN);
   assign in_sweep = in_zero || (state_ff == S_WALK) || (state_ff == S_WALK_DRAIN)
                     || (state_ff == S_MAX) || (state_ff == S_MAX_DRAIN);

   // an entry equal to the pruning candidate counts as no edge on the trial walk
   assign is_edge = (mem_rdata_ff > $signed(WEIGHT_W'(0)))
                    && !(phase_ff == PH_SKIP && mem_rdata_ff == top_ff);

   gcp_mark_unit u_marks (
      .clock (clock),
      .reset (reset),
      .ctrl  (mctrl),
      .stat  (mstat)
   );

   always_comb begin
      state_in     = state_ff;
      phase_in     = phase_ff;
      inside_in    = inside_ff;
      scan_r_in    = scan_r_ff;
      scan_c_in    = scan_c_ff;
      rd_vld_in    = 1'b0;
      rd_addr_in   = {scan_r_ff, scan_c_ff};
      top_in       = top_ff;
      top_first_in = top_first_ff;
      conn_in      = conn_ff;
      pruned_in    = pruned_ff;
      rd_in        = rd_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_data_in  = rsp_data_ff;
      mem_we       = 1'b0;
      mem_waddr    = rd_addr_ff;
      mem_wdata    = '0;
      mem_raddr    = {scan_r_ff, scan_c_ff};
      mctrl        = '0;
      mctrl.n_eff  = n_eff;

      // results of the read issued last cycle
      if (rd_vld_ff) begin
         case (state_ff)
            S_WALK, S_WALK_DRAIN: begin
               mctrl.visit     = is_edge;
               mctrl.visit_idx = rd_addr_ff[VTX_W-1:0];
            end
            S_MAX, S_MAX_DRAIN: begin
               if (top_first_ff || mem_rdata_ff > top_ff) begin
                  top_in = mem_rdata_ff;
               end
               top_first_in = 1'b0;
            end
            S_ZERO, S_ZERO_DRAIN: begin
               mem_we = (mem_rdata_ff == top_ff);
            end
            default: begin
            end
         endcase
      end

      case (state_ff)
         S_IDLE: begin
            mem_raddr = {req_row, req_col};
            if (accept) begin
               inside_in = req_inside;
               conn_in   = 1'b0;
               pruned_in = 1'b0;
               rd_in     = '0;
               phase_in  = (req_cmd == CMD_PRUNE) ? PH_CHECK : PH_PLAIN;
               case (req_cmd)
                  CMD_WRITE: begin
                     mem_we    = req_inside;
                     mem_waddr = {req_row, req_col};
                     mem_wdata = req_weight;
                     state_in  = S_INIT;
                  end
                  CMD_READ: begin
                     state_in = S_READ_CAP;
                  end
                  default: begin
                     state_in = S_INIT;
                  end
               endcase
            end
         end
         S_READ_CAP: begin
            rd_in    = inside_ff ? mem_rdata_ff : '0;
            state_in = S_INIT;
         end
         S_INIT: begin
            mctrl.init = 1'b1;
            state_in   = S_FIND;
         end
         S_FIND: begin
            if (mstat.any_frontier) begin
               mctrl.take     = 1'b1;
               mctrl.take_idx = mstat.first_idx;
               scan_r_in      = mstat.first_idx;
               scan_c_in      = '0;
               state_in       = S_WALK;
            end else begin
               scan_r_in = '0;
               scan_c_in = '0;
               case (phase_ff)
                  PH_CHECK: begin
                     if (mstat.all_reached) begin
                        top_first_in = 1'b1;
                        state_in     = S_MAX;
                     end else begin
                        state_in = S_RESULT;
                     end
                  end
                  PH_SKIP: begin
                     conn_in   = mstat.all_reached;
                     pruned_in = mstat.all_reached;
                     state_in  = mstat.all_reached ? S_ZERO : S_RESULT;
                  end
                  default: begin
                     conn_in  = mstat.all_reached;
                     state_in = S_RESULT;
                  end
               endcase
            end
         end
         S_WALK: begin
            rd_vld_in = 1'b1;
            if (scan_c_ff == nm1) begin
               state_in = S_WALK_DRAIN;
            end else begin
               scan_c_in = scan_c_ff + VTX_W'(1);
            end
         end
         S_WALK_DRAIN: begin
            state_in = S_FIND;
         end
         S_MAX, S_ZERO: begin
            rd_vld_in = 1'b1;
            if (scan_c_ff == nm1) begin
               scan_c_in = '0;
               if (scan_r_ff == nm1) begin
                  state_in = (state_ff == S_MAX) ? S_MAX_DRAIN : S_ZERO_DRAIN;
               end else begin
                  scan_r_in = scan_r_ff + VTX_W'(1);
               end
            end else begin
               scan_c_in = scan_c_ff + VTX_W'(1);
            end
         end
         S_MAX_DRAIN: begin
            phase_in = PH_SKIP;
            state_in = S_INIT;
         end
         S_ZERO_DRAIN: begin
            state_in = S_RESULT;
         end
         S_RESULT: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = RSP_DATA_W'({rd_ff, pruned_ff, conn_ff});
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vcount_ff    <= VCOUNT_RESET;
         state_ff     <= S_IDLE;
         phase_ff     <= PH_PLAIN;
         rd_vld_ff    <= 1'b0;
         top_first_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_wr_en) begin
            vcount_ff <= csr_wr_data;
         end
         state_ff     <= state_in;
         phase_ff     <= phase_in;
         rd_vld_ff    <= rd_vld_in;
         top_first_ff <= top_first_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      inside_ff   <= inside_in;
      scan_r_ff   <= scan_r_in;
      scan_c_ff   <= scan_c_in;
      rd_addr_ff  <= rd_addr_in;
      top_ff      <= top_in;
      conn_ff     <= conn_in;
      pruned_ff   <= pruned_in;
      rd_ff       <= rd_in;
      rsp_data_ff <= rsp_data_in;
   end

   // weight matrix, one write and one registered read per cycle
   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_waddr] <= mem_wdata;
      end
      mem_rdata_ff <= mem[mem_raddr];
   end

   `GCP_ASSERT_NEXT(a_busy_after_accept, clock, reset, accept, state_ff != S_IDLE)
   `GCP_ASSERT_NOW(a_write_states, clock, reset, mem_we, state_ff == S_IDLE || in_zero)
   `GCP_ASSERT_NOW(a_pruned_connected, clock, reset, rsp_valid_ff && rsp_data_ff[1], rsp_data_ff[0])
   `GCP_ASSERT_NOW(a_read_states, clock, reset, rd_vld_ff, in_sweep)

endmodule
